// ===== rtl/pfc_pkg.sv =====
// Package for the PID controller with feedforward: widths, register indexes,
// configuration and pipeline stage structures.
// No dependencies; imported by every module of the controller.
package pfc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int FRAC_W   = 8;
   localparam int ERROR_W  = SAMPLE_W + 1;
   localparam int DIFF_W   = ERROR_W + 1;
   localparam int ACC_W    = 24;
   localparam int PROD_W   = GAIN_W + ERROR_W;
   localparam int DPROD_W  = GAIN_W + DIFF_W;
   localparam int PDF_W    = DPROD_W + 2;
   localparam int TOTAL_W  = PDF_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_DRIVE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_INTEGRAL = 3'd4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

   typedef struct packed {
      logic signed [GAIN_W-1:0]  gain_p;
      logic signed [GAIN_W-1:0]  gain_i;
      logic signed [GAIN_W-1:0]  gain_d;
      logic        [LIMIT_W-1:0] limit_drive;
      logic        [LIMIT_W-1:0] limit_integral;
   } cfg_type;

   // Error stage payload.
   typedef struct packed {
      logic signed [ERROR_W-1:0]  error;
      logic signed [DIFF_W-1:0]   diff;
      logic signed [SAMPLE_W-1:0] feedforward;
   } err_stage_type;

   // Product stage payload.
   typedef struct packed {
      logic signed [PROD_W-1:0]   p_term;
      logic signed [PROD_W-1:0]   i_term;
      logic signed [DPROD_W-1:0]  d_term;
      logic signed [SAMPLE_W-1:0] feedforward;
   } prod_stage_type;

endpackage

// ===== rtl/pfc_error_stage.sv =====
// First pipeline stage: registers the control error and its change since the
// previous transaction. Depends on pfc_pkg.
module pfc_error_stage
   import pfc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [SAMPLE_W-1:0] target,
   input  logic signed [SAMPLE_W-1:0] measured,
   input  logic signed [SAMPLE_W-1:0] feedforward,
   output logic                       out_valid,
   input  logic                       out_ready,
   output err_stage_type              out_data
);

   logic                      valid_ff;
   err_stage_type             data_ff;
   err_stage_type             data_in;
   logic signed [ERROR_W-1:0] last_error_ff;
   logic signed [ERROR_W-1:0] error_in;
   logic                      take;

   // The stage takes a new transaction when empty or when its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Error and error difference, both exact in their widened formats.
   assign error_in = ERROR_W'(target) - ERROR_W'(measured);
   always_comb begin
      data_in.error       = error_in;
      data_in.diff        = DIFF_W'(error_in) - DIFF_W'(last_error_ff);
      data_in.feedforward = feedforward;
   end

   // Control state and error history.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         last_error_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            last_error_ff <= error_in;
         end
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/pfc_mult_stage.sv =====
// Second pipeline stage: the three gain multiplications, each registered.
// Depends on pfc_pkg.
module pfc_mult_stage
   import pfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  err_stage_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output prod_stage_type out_data
);

   logic                      valid_ff;
   prod_stage_type            data_ff;
   prod_stage_type            data_in;
   logic signed [ERROR_W-1:0] error_s;
   logic signed [DIFF_W-1:0]  diff_s;
   logic signed [GAIN_W-1:0]  gain_p_s;
   logic signed [GAIN_W-1:0]  gain_i_s;
   logic signed [GAIN_W-1:0]  gain_d_s;
   logic signed [PROD_W-1:0]  p_prod;
   logic signed [PROD_W-1:0]  i_prod;
   logic signed [DPROD_W-1:0] d_prod;
   logic                      take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Signed operands, then full-width products with 8 fraction bits.
   assign error_s  = in_data.error;
   assign diff_s   = in_data.diff;
   assign gain_p_s = cfg.gain_p;
   assign gain_i_s = cfg.gain_i;
   assign gain_d_s = cfg.gain_d;
   assign p_prod   = PROD_W'(gain_p_s) * PROD_W'(error_s);
   assign i_prod   = PROD_W'(gain_i_s) * PROD_W'(error_s);
   assign d_prod   = DPROD_W'(gain_d_s) * DPROD_W'(diff_s);

   always_comb begin
      data_in.p_term      = p_prod;
      data_in.i_term      = i_prod;
      data_in.d_term      = d_prod;
      data_in.feedforward = in_data.feedforward;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/pfc_accum_stage.sv =====
// Third pipeline stage: updates and clamps the integral accumulator and adds
// the proportional, derivative and feedforward terms. Depends on pfc_pkg.
module pfc_accum_stage
   import pfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [LIMIT_W-1:0]        limit_integral,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  prod_stage_type            in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [PDF_W-1:0]   out_pdf_sum,
   output logic signed [ACC_W-1:0]   out_integral
);

   localparam int ACC_SUM_W = PROD_W + 1;

   logic                        valid_ff;
   logic signed [ACC_W-1:0]     integral_acc_ff;
   logic signed [ACC_W-1:0]     integral_acc_in;
   logic signed [PDF_W-1:0]     pdf_sum_ff;
   logic signed [PDF_W-1:0]     pdf_sum_in;
   logic signed [PROD_W-1:0]    p_s;
   logic signed [PROD_W-1:0]    i_s;
   logic signed [DPROD_W-1:0]   d_s;
   logic signed [SAMPLE_W-1:0]  ff_s;
   logic signed [ACC_W-1:0]     ff_scaled;
   logic signed [ACC_SUM_W-1:0] acc_sum;
   logic signed [ACC_SUM_W-1:0] lim_pos;
   logic signed [ACC_SUM_W-1:0] lim_neg;
   logic                        take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign p_s  = in_data.p_term;
   assign i_s  = in_data.i_term;
   assign d_s  = in_data.d_term;
   assign ff_s = in_data.feedforward;

   // Accumulate and saturate to the integral limit scaled by the fraction.
   assign acc_sum = ACC_SUM_W'(integral_acc_ff) + ACC_SUM_W'(i_s);
   assign lim_pos = ACC_SUM_W'({limit_integral, {FRAC_W{1'b0}}});
   assign lim_neg = -lim_pos;
   always_comb begin
      if (acc_sum > lim_pos) begin
         integral_acc_in = lim_pos[ACC_W-1:0];
      end else if (acc_sum < lim_neg) begin
         integral_acc_in = lim_neg[ACC_W-1:0];
      end else begin
         integral_acc_in = acc_sum[ACC_W-1:0];
      end
   end

   // Sum of the terms that do not depend on the integral.
   assign ff_scaled  = {ff_s, {FRAC_W{1'b0}}};
   assign pdf_sum_in = PDF_W'(p_s) + PDF_W'(d_s) + PDF_W'(ff_scaled);

   // The accumulator changes exactly when this stage loads a transaction, so
   // it always pairs with the registered partial sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         integral_acc_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            integral_acc_ff <= integral_acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pdf_sum_ff <= pdf_sum_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_pdf_sum  = pdf_sum_ff;
   assign out_integral = integral_acc_ff;

endmodule

// ===== rtl/pfc_output_stage.sv =====
// Last pipeline stage: final sum, drive clamp, rounding and the result
// register. Depends on pfc_pkg.
module pfc_output_stage
   import pfc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [LIMIT_W-1:0]         limit_drive,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [PDF_W-1:0]    in_pdf_sum,
   input  logic signed [ACC_W-1:0]    in_integral,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_drive,
   output logic                       rsp_drive_clamped
);

   logic                        valid_ff;
   logic signed [SAMPLE_W-1:0]  drive_ff;
   logic                        clamped_ff;
   logic signed [TOTAL_W-1:0]   total;
   logic signed [TOTAL_W-1:0]   lim_pos;
   logic signed [TOTAL_W-1:0]   lim_neg;
   logic signed [ACC_W-1:0]     bounded;
   logic signed [ACC_W-1:0]     rounded;
   logic                        clamped_in;
   logic signed [SAMPLE_W-1:0]  drive_in;
   logic                        take;

   assign in_ready = !valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   // Full sum and symmetric clamp to the drive limit.
   assign total   = TOTAL_W'(in_pdf_sum) + TOTAL_W'(in_integral);
   assign lim_pos = TOTAL_W'({limit_drive, {FRAC_W{1'b0}}});
   assign lim_neg = -lim_pos;
   always_comb begin
      if (total > lim_pos) begin
         bounded    = lim_pos[ACC_W-1:0];
         clamped_in = 1'b1;
      end else if (total < lim_neg) begin
         bounded    = lim_neg[ACC_W-1:0];
         clamped_in = 1'b1;
      end else begin
         bounded    = total[ACC_W-1:0];
         clamped_in = 1'b0;
      end
   end

   // Round to nearest, ties upward; the bounded value leaves room for the
   // half step, and the result already lies within the drive limit.
   assign rounded  = bounded + ACC_W'(1 <<< (FRAC_W - 1));
   assign drive_in = rounded[FRAC_W +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff   <= drive_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_drive_clamped = clamped_ff;

endmodule

// ===== rtl/pid_feedforward_controller.sv =====
// Positional PID controller with feedforward and clamps; uses pfc_pkg and
// the four pfc stage modules.
// Four registered stages (error, multiply, integral, output) lie between
// an accepted transaction and rsp_valid. Throughput: one transaction per
// cycle while rsp_ready is high; each stage stalls only when full.
// Reset clears all stage valids, the error history and the integral, and
// returns the gains to 0 and both limits to 32767.
module pid_feedforward_controller
   import pfc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_W-1:0]    req_target,
   input  logic signed [SAMPLE_W-1:0]    req_measured,
   input  logic signed [SAMPLE_W-1:0]    req_feedforward,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_W-1:0]    rsp_drive,
   output logic                          rsp_drive_clamped,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   cfg_type                 cfg_ff;
   err_stage_type           err_data;
   prod_stage_type          prod_data;
   logic                    err_valid;
   logic                    err_ready;
   logic                    prod_valid;
   logic                    prod_ready;
   logic                    acc_valid;
   logic                    acc_ready;
   logic signed [PDF_W-1:0] acc_pdf_sum;
   logic signed [ACC_W-1:0] acc_integral;

   // Configuration registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.limit_drive    <= LIMIT_RESET;
         cfg_ff.limit_integral <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P:         cfg_ff.gain_p         <= csr_wdata;
            CSR_GAIN_I:         cfg_ff.gain_i         <= csr_wdata;
            CSR_GAIN_D:         cfg_ff.gain_d         <= csr_wdata;
            CSR_LIMIT_DRIVE:    cfg_ff.limit_drive    <= csr_wdata[LIMIT_W-1:0];
            CSR_LIMIT_INTEGRAL: cfg_ff.limit_integral <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Error and error difference.
   pfc_error_stage u_error (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .target      (req_target),
      .measured    (req_measured),
      .feedforward (req_feedforward),
      .out_valid   (err_valid),
      .out_ready   (err_ready),
      .out_data    (err_data)
   );

   // Gain products.
   pfc_mult_stage u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .in_data   (err_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // Integral update and partial sum.
   pfc_accum_stage u_accum (
      .clock          (clock),
      .reset          (reset),
      .limit_integral (cfg_ff.limit_integral),
      .in_valid       (prod_valid),
      .in_ready       (prod_ready),
      .in_data        (prod_data),
      .out_valid      (acc_valid),
      .out_ready      (acc_ready),
      .out_pdf_sum    (acc_pdf_sum),
      .out_integral   (acc_integral)
   );

   // Drive clamp, rounding and result register.
   pfc_output_stage u_output (
      .clock             (clock),
      .reset             (reset),
      .limit_drive       (cfg_ff.limit_drive),
      .in_valid          (acc_valid),
      .in_ready          (acc_ready),
      .in_pdf_sum        (acc_pdf_sum),
      .in_integral       (acc_integral),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_drive_clamped (rsp_drive_clamped)
   );

endmodule

// ===== rtl/pfc_checker.sv =====
// Port-level checker for the PID controller, attached to the top level by
// the bind statement at the end of this file. Depends on pfc_pkg.
module pfc_checker
   import pfc_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_drive,
   input logic                       rsp_drive_clamped
);

   // The result channel is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_drive) && $stable(rsp_drive_clamped))
      else $error("stalled result changed");

   // With the result side kept ready, an accepted transaction comes out on rsp_valid.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after pipeline latency");

   // The drive limit never exceeds 32767, so the most negative code is unreachable.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive != 16'sh8000)
      else $error("drive outside symmetric range");

endmodule

bind pid_feedforward_controller pfc_checker u_pfc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_drive         (rsp_drive),
   .rsp_drive_clamped (rsp_drive_clamped)
);

// ===== tb/pid_feedforward_controller_test.sv =====
// Self-checking testbench for pid_feedforward_controller: directed and random control steps
// are compared against a cycle-free PID predictor. Idle and stall patterns vary per phase.
// Depends on rtl/pfc_pkg.sv and rtl/pid_feedforward_controller.sv.
module pid_feedforward_controller_test;
   import pfc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint FRAC_ONE = longint'(1) << FRAC_W;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 110;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = CSR_LIMIT_INTEGRAL + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LAST = {CSR_INDEX_W{1'b1}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target;
      logic signed [SAMPLE_W-1:0] measured;
      logic signed [SAMPLE_W-1:0] feedforward;
   } ctrl_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] drive;
      logic                       clamped;
   } drive_rsp_type;

   // Block inputs, all known from time zero.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic signed [SAMPLE_W-1:0] req_target = '0;
   logic signed [SAMPLE_W-1:0] req_measured = '0;
   logic signed [SAMPLE_W-1:0] req_feedforward = '0;
   logic                       rsp_ready = 1'b0;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Block outputs.
   logic                       req_ready;
   logic                       rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_drive;
   logic                       rsp_drive_clamped;

   // Predictor copy of the configuration and the controller state.
   logic signed [GAIN_W-1:0]  gain_p_m = '0;
   logic signed [GAIN_W-1:0]  gain_i_m = '0;
   logic signed [GAIN_W-1:0]  gain_d_m = '0;
   logic        [LIMIT_W-1:0] limit_drive_m = LIMIT_RESET;
   logic        [LIMIT_W-1:0] limit_integral_m = LIMIT_RESET;
   logic signed [ERROR_W-1:0] last_err_m = '0;
   logic signed [ACC_W-1:0]   integral_m = '0;

   ctrl_req_type  step_q[$];
   drive_rsp_type drive_expect_q[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int sent_count = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   pid_feedforward_controller i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target        (req_target),
      .req_measured      (req_measured),
      .req_feedforward   (req_feedforward),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_drive_clamped (rsp_drive_clamped),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // One control step: update the integral and error history, then form the clamped drive.
   function automatic drive_rsp_type predict_drive(input ctrl_req_type r);
      longint err, acc, bound, total, rounded;
      drive_rsp_type o;
      err = longint'(r.target) - longint'(r.measured);
      acc = longint'(integral_m) + longint'(gain_i_m) * err;
      bound = longint'(limit_integral_m) * FRAC_ONE;
      if (acc > bound) acc = bound;
      else if (acc < -bound) acc = -bound;
      total = longint'(gain_p_m) * err + acc
            + longint'(gain_d_m) * (err - longint'(last_err_m))
            + longint'(r.feedforward) * FRAC_ONE;
      integral_m = ACC_W'(acc);
      last_err_m = ERROR_W'(err);
      bound = longint'(limit_drive_m) * FRAC_ONE;
      o.clamped = 1'b0;
      if (total > bound) begin
         total = bound;
         o.clamped = 1'b1;
      end else if (total < -bound) begin
         total = -bound;
         o.clamped = 1'b1;
      end
      // Round to nearest, ties toward plus infinity.
      rounded = (total + FRAC_ONE / 2) >>> FRAC_W;
      if (rounded > longint'(limit_drive_m)) rounded = longint'(limit_drive_m);
      if (rounded < -longint'(limit_drive_m)) rounded = -longint'(limit_drive_m);
      o.drive = SAMPLE_W'(rounded);
      return o;
   endfunction

   // Caller stands at a falling edge; the enable stays high across back-to-back writes.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_GAIN_P:         gain_p_m = data;
         CSR_GAIN_I:         gain_i_m = data;
         CSR_GAIN_D:         gain_d_m = data;
         CSR_LIMIT_DRIVE:    limit_drive_m = data[LIMIT_W-1:0];
         CSR_LIMIT_INTEGRAL: limit_integral_m = data[LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [CSR_DATA_W-1:0] gp, input logic [CSR_DATA_W-1:0] gi,
                               input logic [CSR_DATA_W-1:0] gd, input logic [CSR_DATA_W-1:0] ld,
                               input logic [CSR_DATA_W-1:0] li);
      csr_write(CSR_GAIN_P, gp);
      csr_write(CSR_GAIN_I, gi);
      csr_write(CSR_GAIN_D, gd);
      csr_write(CSR_LIMIT_DRIVE, ld);
      csr_write(CSR_LIMIT_INTEGRAL, li);
      csr_we <= 1'b0;
   endtask

   task automatic push_step(input int t, input int m, input int f);
      step_q.push_back('{SAMPLE_W'(t), SAMPLE_W'(m), SAMPLE_W'(f)});
   endtask

   // Returns at a falling edge once every transaction is sent and answered.
   task automatic wait_idle();
      while (step_q.size() != 0 || sent_count != accepted_count || drive_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] rand_gain();
      case ($urandom_range(3))
         0: return CSR_DATA_W'($urandom);
         1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         default: return CSR_DATA_W'(int'($urandom_range(1200)) - 600);
      endcase
   endfunction

   // Bit 15 of a limit word is random; the block keeps only the low 15 bits.
   function automatic logic [CSR_DATA_W-1:0] rand_limit();
      logic [LIMIT_W-1:0] lim;
      case ($urandom_range(4))
         0: lim = '0;
         1: lim = LIMIT_RESET;
         2: lim = LIMIT_W'($urandom_range(32767));
         default: lim = LIMIT_W'($urandom_range(2000));
      endcase
      return {1'($urandom_range(1)), lim};
   endfunction

   // Mostly a measurement tracking the target, sometimes fully random fields.
   function automatic ctrl_req_type rand_step();
      ctrl_req_type s;
      int span, m_i;
      s.target = SAMPLE_W'($urandom);
      if ($urandom_range(3) == 0) begin
         s.measured = SAMPLE_W'($urandom);
         s.feedforward = SAMPLE_W'($urandom);
      end else begin
         case ($urandom_range(2))
            0: span = 4;
            1: span = 64;
            default: span = 1024;
         endcase
         m_i = int'(s.target) - (int'($urandom_range(2 * span)) - span);
         if (m_i > 32767) m_i = 32767;
         if (m_i < -32768) m_i = -32768;
         s.measured = SAMPLE_W'(m_i);
         s.feedforward = SAMPLE_W'(int'($urandom_range(8191)) - 4096);
      end
      return s;
   endfunction

   // Driver: a new transaction only once the previous one was accepted.
   always @(negedge clock) begin
      ctrl_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || sent_count == accepted_count) begin
         if (step_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            nxt = step_q.pop_front();
            req_valid <= 1'b1;
            req_target <= nxt.target;
            req_measured <= nxt.measured;
            req_feedforward <= nxt.feedforward;
            sent_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Accepted requests are turned into expected drive values.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         accepted_count++;
         drive_expect_q.push_back(predict_drive('{req_target, req_measured, req_feedforward}));
      end
   end

   // Monitor: each response is checked against the oldest expectation.
   always @(posedge clock) begin
      drive_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expect_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: drive %0d clamped %0b",
                        rsp_drive, rsp_drive_clamped);
         end else begin
            want = drive_expect_q.pop_front();
            if (rsp_drive !== want.drive || rsp_drive_clamped !== want.clamped) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: drive exp %0d got %0d, clamped exp %0b got %0b",
                           want.drive, rsp_drive, want.clamped, rsp_drive_clamped);
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pid_feedforward_controller verification failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: pure feedforward, including the negative drive clamp.
      push_step(0, 0, 32767);
      push_step(0, 0, -32768);
      push_step(0, 0, -1);
      wait_idle();

      // Half gain exposes rounding ties; full-scale error hits the drive clamp.
      // Unused register indexes are written and must change nothing.
      for (int idx = CSR_UNUSED_FIRST; idx <= CSR_INDEX_LAST; idx++)
         csr_write(CSR_INDEX_W'(idx), 16'hFFFF);
      apply_config(16'h0080, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
      push_step(1, 0, 0);
      push_step(0, 1, 0);
      push_step(3, 0, 0);
      push_step(0, 3, 0);
      push_step(32767, -32768, 0);
      push_step(-32768, 32767, 0);
      wait_idle();

      // Extreme gains with both limits at zero: drive is always zero.
      apply_config(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
      push_step(32767, -32768, 32767);
      push_step(-32768, 32767, -32768);
      push_step(0, 0, 0);
      push_step(100, -100, 5);
      wait_idle();

      // Opposite extreme gains, limit words with the top bit set.
      apply_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'h83E8, 16'hFFFF);
      push_step(32767, -32768, -32768);
      push_step(-32768, 32767, 32767);
      push_step(0, 0, 0);
      push_step(1, 1, 0);
      push_step(-1, 0, 1);
      wait_idle();

      // Random phases rotate through the idle patterns.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1)
            apply_config(16'h0100, 16'h0010, 16'h0080, 16'h7FFF, 16'h7FFF);
         else
            apply_config(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
            default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            step_q.push_back(rand_step());
         // Back up the pipeline while the sender keeps offering transactions.
         if (ph == 0)
            hold_requests++;
         wait_idle();
      end

      if (mismatch_count == 0 && drive_expect_q.size() == 0)
         $display("pid_feedforward_controller verification clean");
      else
         $display("pid_feedforward_controller verification failed");
      $finish;
   end

endmodule
